// File: sv/wavetable_row_oscillator_top_macros.svh
// ----------------------------------------------------------------------------
// Wavetable row oscillator assertion macros
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef WAVETABLE_ROW_OSCILLATOR_TOP_MACROS_SVH
`define WAVETABLE_ROW_OSCILLATOR_TOP_MACROS_SVH
`ifndef SYNTH
// Property must hold at every clock edge out of reset
`define WRO_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("wavetable row oscillator check failed");
// Expression must never be true out of reset
`define WRO_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("wavetable row oscillator forbidden condition");
`else
`define WRO_ASSERT(label, clk, rst_n, prop)
`define WRO_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// File: sv/wro_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wavetable row oscillator package
// Shared codes, field widths, arithmetic constants and pipeline lane type.
// ----------------------------------------------------------------------------
package wro_pkg;

    // Field widths fixed by the word format
    localparam int FREQ_W   = 24;
    localparam int SCALE_W  = 16;
    localparam int AMP_W    = 9;
    localparam int SAMPLE_W = 8;
    localparam int WEIGHT_W = 8;
    localparam int CFG_W    = 24;

    // Lane index covers the largest supported row length (256 samples)
    localparam int LANE_IDX_W = 8;

    // Register reset values
    localparam logic [FREQ_W-1:0]  BASE_FREQ_RESET = 24'd64000;
    localparam logic [SCALE_W-1:0] ROW_SCALE_RESET = 16'd4231;

    // Midpoint 127.5 in Q.8 and the Q.16 offset (127.5 plus one half)
    localparam logic signed [17:0] MIX_MID    = 18'sd32640;
    localparam logic signed [27:0] ROUND_BIAS = 28'sd8388608;

    // Input operation codes
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_NOTE  = 2'd1,
        OP_TICK  = 2'd2
    } t_op;

    // Configuration register indexes
    typedef enum logic {
        CFG_BASE_FREQ = 1'b0,
        CFG_ROW_SCALE = 1'b1
    } t_cfg_reg;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_TICK    = 3'd1,
        ST_PRODUCT = 3'd2,
        ST_INDEX   = 3'd3,
        ST_SWEEP   = 3'd4
    } t_state;

    // One entry moving through the rebuild pipeline
    typedef struct packed {
        logic                  valid;
        logic                  last;
        logic [LANE_IDX_W-1:0] idx;
    } t_lane;

endpackage

// File: sv/wro_wave_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wave table memory
// One write port and two registered read ports for the two crossfade rows.
// ----------------------------------------------------------------------------
module wro_wave_mem #(
    parameter int DEPTH = 16384,
    parameter int AW    = 14
) (
    input  logic                         i_clk,
    input  logic                         i_wr_en,
    input  logic [AW-1:0]                i_wr_addr,
    input  logic [wro_pkg::SAMPLE_W-1:0] i_wr_data,
    input  logic [AW-1:0]                i_rd_addr_a,
    input  logic [AW-1:0]                i_rd_addr_b,
    output logic [wro_pkg::SAMPLE_W-1:0] o_rd_data_a,
    output logic [wro_pkg::SAMPLE_W-1:0] o_rd_data_b
);
    import wro_pkg::*;

    logic [SAMPLE_W-1:0] r_mem [DEPTH];

    // Store table bytes
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read both rows through registered outputs
    always_ff @(posedge i_clk) begin
        o_rd_data_a <= r_mem[i_rd_addr_a];
        o_rd_data_b <= r_mem[i_rd_addr_b];
    end

endmodule

// File: sv/wro_row_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Row buffer memory
// Holds the shaped row that ticks play; one write and one registered read.
// ----------------------------------------------------------------------------
module wro_row_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                         i_clk,
    input  logic                         i_wr_en,
    input  logic [AW-1:0]                i_wr_addr,
    input  logic [wro_pkg::SAMPLE_W-1:0] i_wr_data,
    input  logic [AW-1:0]                i_rd_addr,
    output logic [wro_pkg::SAMPLE_W-1:0] o_rd_data
);
    import wro_pkg::*;

    logic [SAMPLE_W-1:0] r_mem [DEPTH];

    // Store shaped entries
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read the play position through a registered output
    always_ff @(posedge i_clk) begin
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

// File: sv/wro_shape.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Entry shaping pipeline
// Crossfade two table bytes, scale about the midpoint, round and clamp.
// ----------------------------------------------------------------------------
module wro_shape (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  wro_pkg::t_lane               i_issue,
    input  logic [wro_pkg::SAMPLE_W-1:0] i_data_a,
    input  logic [wro_pkg::SAMPLE_W-1:0] i_data_b,
    input  logic [wro_pkg::WEIGHT_W-1:0] i_weight,
    input  logic [wro_pkg::AMP_W-1:0]    i_amp,
    output wro_pkg::t_lane               o_wr,
    output logic [wro_pkg::SAMPLE_W-1:0] o_wr_data
);
    import wro_pkg::*;

    t_lane r_lane_rd;
    t_lane r_lane_mix;
    t_lane r_lane_t;

    logic signed [8:0]  delta;
    logic signed [17:0] w_delta;
    logic signed [17:0] mix_full;
    logic [16:0]        r_mix;
    logic signed [17:0] centered;
    logic signed [27:0] scaled;
    logic signed [27:0] r_t;

    // Mix = a*256 + w*(b - a), always within 0..65280
    assign delta    = $signed({1'b0, i_data_b}) - $signed({1'b0, i_data_a});
    assign w_delta  = $signed({1'b0, i_weight}) * delta;
    assign mix_full = $signed({1'b0, i_data_a, 8'b0}) + w_delta;

    // Center about 127.5 and apply gain with the rounding offset
    assign centered = $signed({1'b0, r_mix}) - MIX_MID;
    assign scaled   = centered * $signed({1'b0, i_amp});

    // Advance lane tags alongside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane_rd  <= '0;
            r_lane_mix <= '0;
            r_lane_t   <= '0;
        end else begin
            r_lane_rd  <= i_issue;
            r_lane_mix <= r_lane_rd;
            r_lane_t   <= r_lane_mix;
        end
    end

    // Data stages
    always_ff @(posedge i_clk) begin
        r_mix <= mix_full[16:0];
        r_t   <= scaled + ROUND_BIAS;
    end

    // Clamp the Q.16 result to the output code range
    always_comb begin
        priority if (r_t[27]) begin
            o_wr_data = '0;
        end else if (|r_t[26:24]) begin
            o_wr_data = '1;
        end else begin
            o_wr_data = r_t[23:16];
        end
    end

    assign o_wr = r_lane_t;

endmodule

// File: sv/wavetable_row_oscillator_top.sv
`timescale 1ns / 1ps
`include "wavetable_row_oscillator_top_macros.svh"
// ----------------------------------------------------------------------------
// Wavetable row oscillator
// Table writes, note setup with row crossfade and gain, and tick playback.
//
//   Channel   Handshake                  Payload
//   -------   -------------------------  --------------------------------------
//   input     i_in_valid / o_in_ready    i_op i_row i_column i_table_value
//                                        i_frequency i_amplitude
//   output    o_out_valid / i_out_ready  o_sample
//   config    i_cfg_we                   i_cfg_index i_cfg_data
//
// A table write lands when the word is accepted; a tick reads the row buffer,
// then loads the output register. A set-note word forms the frequency product,
// then clamps the index, then sweeps one row entry per cycle through the
// two-read-port wave memory and a three-stage shaping pipeline. A tick waits
// while an earlier word is unread.
// Reset is synchronous; the row buffer reads as zero until the first note.
// ----------------------------------------------------------------------------
module wavetable_row_oscillator_top #(
    parameter int SAMPLES_PER_CYCLE = 64,
    parameter int NUMBER_OF_ROWS    = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_op,
    input  logic [7:0]                   i_row,
    input  logic [5:0]                   i_column,
    input  logic [7:0]                   i_table_value,
    input  logic [wro_pkg::FREQ_W-1:0]   i_frequency,
    input  logic [wro_pkg::AMP_W-1:0]    i_amplitude,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [wro_pkg::SAMPLE_W-1:0] o_sample,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_index,
    input  logic [wro_pkg::CFG_W-1:0]    i_cfg_data
);
    import wro_pkg::*;

    localparam int DEPTH     = NUMBER_OF_ROWS * SAMPLES_PER_CYCLE;
    localparam int AW        = $clog2(DEPTH);
    localparam int CW        = $clog2(SAMPLES_PER_CYCLE);
    localparam int LW        = $clog2(NUMBER_OF_ROWS);
    localparam int INDEX_MAX = (NUMBER_OF_ROWS - 1) * 256 - 1;

    t_state              r_state;
    t_state              n_state;
    logic [FREQ_W-1:0]   r_base_freq;
    logic [SCALE_W-1:0]  r_row_scale;
    logic [FREQ_W-1:0]   r_freq;
    logic [AMP_W-1:0]    r_amp;
    logic [FREQ_W-1:0]   r_index_raw;
    logic [WEIGHT_W-1:0] r_weight;
    logic [AW-1:0]       r_base_a;
    logic [AW-1:0]       r_base_b;
    logic [CW-1:0]       r_issue_cnt;
    logic                r_issue_done;
    logic [CW-1:0]       r_cursor;
    logic [CW-1:0]       n_cursor;
    logic                r_built;
    logic                r_tick_zero;
    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_out_sample;

    logic                 in_fire;
    logic                 wave_wr_en;
    logic [AW-1:0]        wave_wr_addr;
    logic [FREQ_W-1:0]    freq_diff;
    logic [FREQ_W-1:0]    index_clamped;
    logic [LW-1:0]        left_row;
    logic [AW-1:0]        base_a;
    t_lane                issue;
    t_lane                shape_wr;
    logic [SAMPLE_W-1:0]  shape_data;
    logic [SAMPLE_W-1:0]  data_a;
    logic [SAMPLE_W-1:0]  data_b;
    logic [SAMPLE_W-1:0]  row_rd_data;

    // Ticks need a free output register; other words only need the idle state
    assign o_in_ready = (r_state == ST_IDLE) && (!r_out_valid || (i_op != OP_TICK));
    assign in_fire    = i_in_valid && o_in_ready;

    // Table write address, dropped when outside the table
    assign wave_wr_en = in_fire && (i_op == OP_WRITE)
                        && (32'(i_row) < NUMBER_OF_ROWS)
                        && (32'(i_column) < SAMPLES_PER_CYCLE);
    assign wave_wr_addr = AW'(i_row) * AW'(SAMPLES_PER_CYCLE) + AW'(i_column);

    // Frequency offset above row zero
    assign freq_diff = (r_freq > r_base_freq) ? (r_freq - r_base_freq) : '0;

    // Clamp the fractional row index and locate the left row
    assign index_clamped = (r_index_raw > FREQ_W'(INDEX_MAX)) ? FREQ_W'(INDEX_MAX)
                                                              : r_index_raw;
    assign left_row      = index_clamped[8 +: LW];
    assign base_a        = AW'(left_row) * AW'(SAMPLES_PER_CYCLE);

    // Issue one row entry per sweep cycle
    assign issue.valid = (r_state == ST_SWEEP) && !r_issue_done;
    assign issue.last  = (r_issue_cnt == CW'(SAMPLES_PER_CYCLE - 1));
    assign issue.idx   = LANE_IDX_W'(r_issue_cnt);

    // Wrap the play cursor
    assign n_cursor = (r_cursor == CW'(SAMPLES_PER_CYCLE - 1)) ? '0 : r_cursor + 1'b1;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire && (i_op == OP_NOTE)) begin
                    n_state = ST_PRODUCT;
                end else if (in_fire && (i_op == OP_TICK)) begin
                    n_state = ST_TICK;
                end
            end
            ST_TICK:    n_state = ST_IDLE;
            ST_PRODUCT: n_state = ST_INDEX;
            ST_INDEX:   n_state = ST_SWEEP;
            ST_SWEEP: begin
                if (shape_wr.valid && shape_wr.last) begin
                    n_state = ST_IDLE;
                end
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_base_freq  <= BASE_FREQ_RESET;
            r_row_scale  <= ROW_SCALE_RESET;
            r_issue_cnt  <= '0;
            r_issue_done <= 1'b0;
            r_cursor     <= '0;
            r_built      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_BASE_FREQ: r_base_freq <= i_cfg_data;
                    CFG_ROW_SCALE: r_row_scale <= i_cfg_data[SCALE_W-1:0];
                    default:       r_base_freq <= r_base_freq;
                endcase
            end
            if (r_state == ST_INDEX) begin
                r_issue_cnt  <= '0;
                r_issue_done <= 1'b0;
            end else if (issue.valid) begin
                r_issue_cnt <= r_issue_cnt + 1'b1;
                if (issue.last) begin
                    r_issue_done <= 1'b1;
                end
            end
            if (shape_wr.valid && shape_wr.last) begin
                r_built <= 1'b1;
            end
            if (in_fire && (i_op == OP_TICK)) begin
                r_cursor <= n_cursor;
            end
            if (r_state == ST_TICK) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire && (i_op == OP_NOTE)) begin
            r_freq <= i_frequency;
            r_amp  <= i_amplitude;
        end
        if (r_state == ST_PRODUCT) begin
            r_index_raw <= 24'((40'(freq_diff) * 40'(r_row_scale)) >> 16);
        end
        if (r_state == ST_INDEX) begin
            r_weight <= index_clamped[7:0];
            r_base_a <= base_a;
            r_base_b <= base_a + AW'(SAMPLES_PER_CYCLE);
        end
        if (in_fire && (i_op == OP_TICK)) begin
            r_tick_zero <= !r_built;
        end
        if (r_state == ST_TICK) begin
            r_out_sample <= r_tick_zero ? '0 : row_rd_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_sample    = r_out_sample;

    wro_wave_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_wave_mem (
        .i_clk       (i_clk),
        .i_wr_en     (wave_wr_en),
        .i_wr_addr   (wave_wr_addr),
        .i_wr_data   (i_table_value),
        .i_rd_addr_a (r_base_a + AW'(r_issue_cnt)),
        .i_rd_addr_b (r_base_b + AW'(r_issue_cnt)),
        .o_rd_data_a (data_a),
        .o_rd_data_b (data_b)
    );

    wro_shape u_shape (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_issue   (issue),
        .i_data_a  (data_a),
        .i_data_b  (data_b),
        .i_weight  (r_weight),
        .i_amp     (r_amp),
        .o_wr      (shape_wr),
        .o_wr_data (shape_data)
    );

    wro_row_mem #(
        .DEPTH (SAMPLES_PER_CYCLE),
        .AW    (CW)
    ) u_row_mem (
        .i_clk     (i_clk),
        .i_wr_en   (shape_wr.valid),
        .i_wr_addr (shape_wr.idx[CW-1:0]),
        .i_wr_data (shape_data),
        .i_rd_addr (r_cursor),
        .o_rd_data (row_rd_data)
    );

    // Row buffer is written only during a sweep
    `WRO_ASSERT(a_wr_in_sweep, i_clk, i_rst_n, shape_wr.valid |-> (r_state == ST_SWEEP))
    // A tick result never lands on an unread word
    `WRO_ASSERT_NEVER(a_tick_overrun, i_clk, i_rst_n, (r_state == ST_TICK) && r_out_valid)
    // Last shaped entry closes the rebuild
    `WRO_ASSERT(a_sweep_close, i_clk, i_rst_n, (shape_wr.valid && shape_wr.last) |=> ((r_state == ST_IDLE) && r_built))
    // No word is taken while the rebuild is running
    `WRO_ASSERT_NEVER(a_busy_accept, i_clk, i_rst_n, (r_state != ST_IDLE) && in_fire)
    // Play cursor stays inside the row
    `WRO_ASSERT(a_cursor_range, i_clk, i_rst_n, r_cursor <= CW'(SAMPLES_PER_CYCLE - 1))

endmodule
